// ===== rtl/tnrx_pkg.sv =====
// Shared types and constants for the telnet receive command parser.
package tnrx_pkg;

  // Telnet protocol bytes.
  localparam logic [7:0] IAC_BYTE  = 8'hFF;
  localparam logic [7:0] SB_BYTE   = 8'hFA;
  localparam logic [7:0] SE_BYTE   = 8'hF0;
  localparam logic [7:0] WILL_BYTE = 8'hFB;
  localparam logic [7:0] DONT_BYTE = 8'hFE;

  // Reset value of the modem-signal option number.
  localparam logic [7:0] SIG_OPT_RESET = 8'd78;

  // Signal letters carried in the modem-signal suboption.
  localparam logic [7:0] LETTER_DSR_ON  = 8'h44; // 'D'
  localparam logic [7:0] LETTER_DSR_OFF = 8'h64; // 'd'
  localparam logic [7:0] LETTER_CD_ON   = 8'h43; // 'C'
  localparam logic [7:0] LETTER_CD_OFF  = 8'h63; // 'c'
  localparam logic [7:0] LETTER_CTS_ON  = 8'h52; // 'R'
  localparam logic [7:0] LETTER_CTS_OFF = 8'h72; // 'r'

  typedef enum logic [2:0] {
    MODE_DATA,
    MODE_IAC,
    MODE_OPT,
    MODE_SUB,
    MODE_SUB_IAC
  } parse_mode_t;

  typedef enum logic [1:0] {
    CMD_WILL,
    CMD_WONT,
    CMD_DO,
    CMD_DONT
  } cmd_kind_t;

  // How many bytes of the current SB block are held.
  typedef enum logic [1:0] {
    SUB_NONE,
    SUB_CODE,
    SUB_FULL
  } sub_count_t;

  typedef struct packed {
    logic       data_valid;
    logic [7:0] data_byte;
    logic       cmd_valid;
    logic [1:0] cmd_kind;
    logic [7:0] cmd_option;
    logic       reply_will;
    logic       sub_done;
    logic [7:0] sub_option;
    logic       dsr_state;
    logic       carrier_state;
    logic       cts_state;
    logic       signals_enabled;
  } tnrx_result_t;

endpackage

// ===== rtl/telnet_rx_command_parser_top.sv =====
// Top level of the telnet receive command parser.
//
// The block takes one received telnet byte per input beat on rx_byte
// (in_valid / in_ready) and returns exactly one result beat per input
// beat (out_valid / out_ready). Ordinary bytes and escaped 0xFF bytes
// come out as data; IAC command sequences are stripped, and only negotiation
// commands and finished suboption blocks are reported; the modem-signal
// flags are shown as they stand after each byte.
// The result of a byte is registered: once the byte is accepted, it is on the
// output ports in the next cycle. Throughput is one byte per cycle while the
// receiver does not stall, set by the single result register; the parser state
// updates in the same cycle the byte is accepted.
// When the receiver stalls, the result register holds its beat and
// in_ready stays high only if that beat is being taken in the same cycle,
// so the block pauses for exactly as long as the receiver does.
// The option number of the modem-signal extension is written through
// cfg_wr_en / cfg_wr_data; it should be changed only while the block is idle.
// A synchronous reset returns the parser to plain data mode, sets DSR and
// CTS, clears carrier and signalling, restores the option number to 78
// and empties the result register.
module telnet_rx_command_parser_top
  import tnrx_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       data_valid,
  output logic [7:0] data_byte,
  output logic       cmd_valid,
  output logic [1:0] cmd_kind,
  output logic [7:0] cmd_option,
  output logic       reply_will,
  output logic       sub_done,
  output logic [7:0] sub_option,
  output logic       dsr_state,
  output logic       carrier_state,
  output logic       cts_state,
  output logic       signals_enabled
);

  logic         sig_opt;
  logic [7:0]   signal_option_code;
  logic         accept;
  tnrx_result_t res_comb;
  tnrx_result_t res_q;

  // Configuration register: the option number of the modem-signal extension.
  always_ff @(posedge clk) begin
    if (rst) begin
      signal_option_code <= SIG_OPT_RESET;
    end else if (cfg_wr_en) begin
      signal_option_code <= cfg_wr_data;
    end
  end

  // An offered beat is taken whenever the result register can accept its result.
  assign accept  = in_valid && in_ready;
  assign sig_opt = accept;

  tnrx_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .accept  (sig_opt),
    .rx_byte (rx_byte),
    .sig_opt (signal_option_code),
    .res     (res_comb)
  );

  tnrx_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (accept),
    .res_in    (res_comb),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .can_load  (in_ready),
    .res_q     (res_q)
  );

  assign data_valid      = res_q.data_valid;
  assign data_byte       = res_q.data_byte;
  assign cmd_valid       = res_q.cmd_valid;
  assign cmd_kind        = res_q.cmd_kind;
  assign cmd_option      = res_q.cmd_option;
  assign reply_will      = res_q.reply_will;
  assign sub_done        = res_q.sub_done;
  assign sub_option      = res_q.sub_option;
  assign dsr_state       = res_q.dsr_state;
  assign carrier_state   = res_q.carrier_state;
  assign cts_state       = res_q.cts_state;
  assign signals_enabled = res_q.signals_enabled;

endmodule

// ===== rtl/tnrx_parser.sv =====
// Parser state machine: holds the telnet parse state and forms one result per byte.
module tnrx_parser
  import tnrx_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         accept,
  input  logic [7:0]   rx_byte,
  input  logic [7:0]   sig_opt,
  output tnrx_result_t res
);

  parse_mode_t mode, mode_next;
  cmd_kind_t   pending_kind, pending_kind_next;
  sub_count_t  sub_count, sub_count_next;
  logic [7:0]  sub_code, sub_code_next;
  logic [7:0]  sub_first, sub_first_next;
  logic        dsr_flag, dsr_flag_next;
  logic        carrier_flag, carrier_flag_next;
  logic        cts_flag, cts_flag_next;
  logic        signal_enable, signal_enable_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_DATA;
      pending_kind  <= CMD_WILL;
      sub_count     <= SUB_NONE;
      sub_code      <= '0;
      sub_first     <= '0;
      dsr_flag      <= 1'b1;
      carrier_flag  <= 1'b0;
      cts_flag      <= 1'b1;
      signal_enable <= 1'b0;
    end else if (accept) begin
      mode          <= mode_next;
      pending_kind  <= pending_kind_next;
      sub_count     <= sub_count_next;
      sub_code      <= sub_code_next;
      sub_first     <= sub_first_next;
      dsr_flag      <= dsr_flag_next;
      carrier_flag  <= carrier_flag_next;
      cts_flag      <= cts_flag_next;
      signal_enable <= signal_enable_next;
    end
  end

  always_comb begin
    logic keep;
    keep               = 1'b0;
    mode_next          = mode;
    pending_kind_next  = pending_kind;
    sub_count_next     = sub_count;
    sub_code_next      = sub_code;
    sub_first_next     = sub_first;
    dsr_flag_next      = dsr_flag;
    carrier_flag_next  = carrier_flag;
    cts_flag_next      = cts_flag;
    signal_enable_next = signal_enable;
    res                = '0;

    unique case (mode)
      MODE_IAC: begin
        mode_next = MODE_DATA;
        if (rx_byte == IAC_BYTE) begin
          res.data_valid = 1'b1;
          res.data_byte  = rx_byte;
        end else if (rx_byte >= WILL_BYTE && rx_byte <= DONT_BYTE) begin
          // WILL..DONT are consecutive codes; the low two bits plus one give the kind.
          pending_kind_next = cmd_kind_t'(rx_byte[1:0] + 2'd1);
          mode_next         = MODE_OPT;
        end else if (rx_byte == SB_BYTE) begin
          sub_count_next = SUB_NONE;
          sub_code_next  = '0;
          sub_first_next = '0;
          mode_next      = MODE_SUB;
        end
      end
      MODE_OPT: begin
        res.cmd_valid  = 1'b1;
        res.cmd_kind   = pending_kind;
        res.cmd_option = rx_byte;
        if (rx_byte == sig_opt) begin
          if (pending_kind == CMD_WILL) begin
            signal_enable_next = 1'b1;
          end else if (pending_kind == CMD_DO && !signal_enable) begin
            res.reply_will     = 1'b1;
            signal_enable_next = 1'b1;
          end
        end
        mode_next = MODE_DATA;
      end
      MODE_SUB: begin
        if (rx_byte == IAC_BYTE) begin
          mode_next = MODE_SUB_IAC;
        end else begin
          keep = 1'b1;
        end
      end
      MODE_SUB_IAC: begin
        if (rx_byte == SE_BYTE) begin
          res.sub_done   = 1'b1;
          res.sub_option = (sub_count != SUB_NONE) ? sub_code : 8'd0;
          if (sub_count == SUB_FULL && sub_code == sig_opt) begin
            case (sub_first)
              LETTER_DSR_ON:  dsr_flag_next     = 1'b1;
              LETTER_DSR_OFF: dsr_flag_next     = 1'b0;
              LETTER_CD_ON:   carrier_flag_next = 1'b1;
              LETTER_CD_OFF:  carrier_flag_next = 1'b0;
              LETTER_CTS_ON:  cts_flag_next     = 1'b1;
              LETTER_CTS_OFF: cts_flag_next     = 1'b0;
              default: ;
            endcase
          end
          sub_count_next = SUB_NONE;
          mode_next      = MODE_DATA;
        end else begin
          // An escaped byte inside the block counts as block content.
          keep      = 1'b1;
          mode_next = MODE_SUB;
        end
      end
      default: begin
        if (rx_byte == IAC_BYTE) begin
          mode_next = MODE_IAC;
        end else begin
          res.data_valid = 1'b1;
          res.data_byte  = rx_byte;
          mode_next      = MODE_DATA;
        end
      end
    endcase

    // Only the option code and the first payload byte of a block are kept.
    if (keep) begin
      if (sub_count == SUB_NONE) begin
        sub_code_next  = rx_byte;
        sub_count_next = SUB_CODE;
      end else if (sub_count == SUB_CODE) begin
        sub_first_next = rx_byte;
        sub_count_next = SUB_FULL;
      end
    end

    res.dsr_state       = dsr_flag_next;
    res.carrier_state   = carrier_flag_next;
    res.cts_state       = cts_flag_next;
    res.signals_enabled = signal_enable_next;
  end

endmodule

// ===== rtl/tnrx_out_stage.sv =====
// Result register that holds one finished result until the receiver takes it.
module tnrx_out_stage
  import tnrx_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         load,
  input  tnrx_result_t res_in,
  input  logic         out_ready,
  output logic         out_valid,
  output logic         can_load,
  output tnrx_result_t res_q
);

  // A new result may enter when the register is empty or drains this cycle.
  assign can_load = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (can_load) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && can_load) begin
      res_q <= res_in;
    end
  end

endmodule

// ===== rtl/tnrx_checker.sv =====
// Port-level checker for the telnet receive command parser, bound to the top level.
module tnrx_checker
  import tnrx_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic [7:0] rx_byte,
  input logic       cfg_wr_en,
  input logic [7:0] cfg_wr_data,
  input logic       out_valid,
  input logic       out_ready,
  input logic       data_valid,
  input logic [7:0] data_byte,
  input logic       cmd_valid,
  input logic [1:0] cmd_kind,
  input logic [7:0] cmd_option,
  input logic       reply_will,
  input logic       sub_done,
  input logic [7:0] sub_option,
  input logic       dsr_state,
  input logic       carrier_state,
  input logic       cts_state,
  input logic       signals_enabled
);

  // A stalled result beat keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(data_byte) && $stable(cmd_option)
      && $stable(sub_option))
    else $error("result beat changed while stalled");

  // One byte completes at most one kind of event.
  a_one_event: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot0({data_valid, cmd_valid, sub_done}))
    else $error("more than one event in one result beat");

  // A WILL reply is requested only by a DO, and signalling is then on.
  a_reply: assert property (@(posedge clk) disable iff (rst)
    out_valid && reply_will |-> cmd_valid && cmd_kind == CMD_DO && signals_enabled)
    else $error("WILL reply without a DO that enables signalling");

  // Once signalling is enabled in a taken beat, a valid beat right behind it shows it enabled too.
  a_sig_sticky: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && signals_enabled ##1 out_valid |-> signals_enabled)
    else $error("signalling dropped without reset");

  // Fields of absent events read as zero.
  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (data_valid || data_byte == 8'd0) && (cmd_valid || cmd_option == 8'd0)
      && (sub_done || sub_option == 8'd0))
    else $error("field of an absent event is not zero");

endmodule

bind telnet_rx_command_parser_top tnrx_checker u_tnrx_checker (.*);
